// File: hdl/imgrot_pkg.sv
// ----------------------------------------------------------------------------
// imgrot_pkg
// Shared types, codes and defaults for the quarter-turn frame rotator.
// ----------------------------------------------------------------------------
package imgrot_pkg;

    // Default frame store size
    localparam int unsigned MAX_WIDTH_DEF  = 128;
    localparam int unsigned MAX_HEIGHT_DEF = 128;

    // Depth of the command queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    // Fixed field widths
    localparam int unsigned DIM_W    = 8;
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned PIXEL_W  = 3 * CHAN_W;
    localparam int unsigned COORD_W  = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned OUT_DATA_W = 40;

    // Command codes carried on s_tuser
    localparam logic CMD_STORE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_MODE = 2'd2;

    // Rotation modes
    typedef enum logic [1:0] {
        ROT_90   = 2'd0,
        ROT_180  = 2'd1,
        ROT_270  = 2'd2,
        ROT_NONE = 2'd3
    } rot_mode_t;

    // Register reset values
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 8'd128;

    // Queue entry, less the memory address
    typedef struct packed {
        logic               kind;
        logic [PIXEL_W-1:0] pixel;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } entry_info_t;

endpackage

// File: hdl/imgrot_front.sv
// ----------------------------------------------------------------------------
// imgrot_front
// Accepts commands, holds configuration and the store/read counters, and
// turns each command into a queue entry with its frame store address.
// ----------------------------------------------------------------------------
module imgrot_front #(
    parameter int unsigned MAX_WIDTH  = imgrot_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = imgrot_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned ENTRY_W    = 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imgrot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imgrot_pkg::DIM_W-1:0]        cfg_data,
    // command stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tuser,
    input  logic [imgrot_pkg::PIXEL_W-1:0]      s_tdata,
    // queue write side
    output logic                                push,
    output logic [ENTRY_W-1:0]                  push_data,
    input  logic                                full
);

    localparam int unsigned XW = $clog2(MAX_WIDTH);
    localparam int unsigned YW = $clog2(MAX_HEIGHT);
    localparam int unsigned CW = (XW > YW) ? XW : YW;
    localparam int unsigned AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

    logic [imgrot_pkg::DIM_W-1:0] width_reg, width_next;
    logic [imgrot_pkg::DIM_W-1:0] height_reg, height_next;
    imgrot_pkg::rot_mode_t        mode_reg, mode_next;

    logic [XW-1:0] st_col_reg, st_col_next;
    logic [YW-1:0] st_row_reg, st_row_next;
    logic [CW-1:0] rd_col_reg, rd_col_next;
    logic [CW-1:0] rd_row_reg, rd_row_next;

    logic [XW:0]   w;
    logic [YW:0]   h;
    logic [CW:0]   wx, hx, ow, oh;
    logic [XW-1:0] sc;
    logic [YW-1:0] sr;
    logic [XW:0]   sc1;
    logic [YW:0]   sr1;
    logic [CW-1:0] rx, ry;
    logic [CW:0]   rc1, rr1;
    logic [CW:0]   sx_f, sy_f;
    logic [AW-1:0] st_addr, rd_addr;
    logic          last;
    imgrot_pkg::entry_info_t info;

    assign cfg_ready = 1'b1;
    assign s_tready  = !full;
    assign push      = s_tvalid && !full;

    // Clamp the frame size into 1..MAX
    always_comb begin
        if (width_reg == '0) begin
            w = (XW+1)'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w = (XW+1)'(MAX_WIDTH);
        end else begin
            w = (XW+1)'(width_reg);
        end
        if (height_reg == '0) begin
            h = (YW+1)'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h = (YW+1)'(MAX_HEIGHT);
        end else begin
            h = (YW+1)'(height_reg);
        end
        wx = (CW+1)'(w);
        hx = (CW+1)'(h);
        if (mode_reg == imgrot_pkg::ROT_90 || mode_reg == imgrot_pkg::ROT_270) begin
            ow = hx;
            oh = wx;
        end else begin
            ow = wx;
            oh = hx;
        end
    end

    // Store side: restart out-of-range counters, form address, advance
    always_comb begin
        sc  = ({1'b0, st_col_reg} >= w) ? '0 : st_col_reg;
        sr  = ({1'b0, st_row_reg} >= h) ? '0 : st_row_reg;
        sc1 = {1'b0, sc} + (XW+1)'(1);
        sr1 = {1'b0, sr} + (YW+1)'(1);
        st_addr = AW'(sr) * AW'(MAX_WIDTH) + AW'(sc);
        if (sc1 >= w) begin
            st_col_next = '0;
            st_row_next = (sr1 >= h) ? '0 : YW'(sr1);
        end else begin
            st_col_next = XW'(sc1);
            st_row_next = sr;
        end
    end

    // Read side: map output position to source position
    always_comb begin
        rx  = ({1'b0, rd_col_reg} >= ow) ? '0 : rd_col_reg;
        ry  = ({1'b0, rd_row_reg} >= oh) ? '0 : rd_row_reg;
        rc1 = {1'b0, rx} + (CW+1)'(1);
        rr1 = {1'b0, ry} + (CW+1)'(1);
        case (mode_reg)
            imgrot_pkg::ROT_90: begin
                sx_f = {1'b0, ry};
                sy_f = hx - (CW+1)'(1) - {1'b0, rx};
            end
            imgrot_pkg::ROT_180: begin
                sx_f = wx - (CW+1)'(1) - {1'b0, rx};
                sy_f = hx - (CW+1)'(1) - {1'b0, ry};
            end
            imgrot_pkg::ROT_270: begin
                sx_f = wx - (CW+1)'(1) - {1'b0, ry};
                sy_f = {1'b0, rx};
            end
            default: begin
                sx_f = {1'b0, rx};
                sy_f = {1'b0, ry};
            end
        endcase
        rd_addr = AW'(YW'(sy_f)) * AW'(MAX_WIDTH) + AW'(XW'(sx_f));
        last    = ({1'b0, rx} == ow - (CW+1)'(1)) && ({1'b0, ry} == oh - (CW+1)'(1));
        if (rc1 >= ow) begin
            rd_col_next = '0;
            rd_row_next = (rr1 >= oh) ? '0 : CW'(rr1);
        end else begin
            rd_col_next = CW'(rc1);
            rd_row_next = ry;
        end
    end

    // Build the queue entry
    always_comb begin
        info.kind  = s_tuser;
        info.pixel = s_tdata;
        info.col   = imgrot_pkg::COORD_W'(rx);
        info.row   = imgrot_pkg::COORD_W'(ry);
        info.last  = last;
        push_data  = {info, (s_tuser == imgrot_pkg::CMD_STORE) ? st_addr : rd_addr};
    end

    // Configuration writes; unknown indexes are dropped
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        if (cfg_valid) begin
            case (cfg_index)
                imgrot_pkg::CFG_FRAME_WIDTH:   width_next  = cfg_data;
                imgrot_pkg::CFG_FRAME_HEIGHT:  height_next = cfg_data;
                imgrot_pkg::CFG_ROTATION_MODE: begin
                    mode_next = imgrot_pkg::rot_mode_t'(cfg_data[1:0]);
                end
                default: ;
            endcase
        end
    end

    // Hold configuration and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= imgrot_pkg::FRAME_WIDTH_RST;
            height_reg <= imgrot_pkg::FRAME_HEIGHT_RST;
            mode_reg   <= imgrot_pkg::ROT_90;
            st_col_reg <= '0;
            st_row_reg <= '0;
            rd_col_reg <= '0;
            rd_row_reg <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
            if (push && s_tuser == imgrot_pkg::CMD_STORE) begin
                st_col_reg <= st_col_next;
                st_row_reg <= st_row_next;
            end
            if (push && s_tuser == imgrot_pkg::CMD_READ) begin
                rd_col_reg <= rd_col_next;
                rd_row_reg <= rd_row_next;
            end
        end
    end

endmodule

// File: hdl/imgrot_fifo.sv
// ----------------------------------------------------------------------------
// imgrot_fifo
// Small command queue between the front and back parts of the rotator.
// ----------------------------------------------------------------------------
module imgrot_fifo #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = imgrot_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign full     = (count_reg == NW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slots[rd_ptr_reg];

    // Advance pointers with wrap at the depth
    always_comb begin
        wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // Never take from an empty queue or add to a full one
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue pushed while full");

endmodule

// File: hdl/imgrot_back.sv
// ----------------------------------------------------------------------------
// imgrot_back
// Executes queued commands against the frame store and drives the result
// stream through a registered output stage.
// ----------------------------------------------------------------------------
module imgrot_back #(
    parameter int unsigned MAX_WIDTH  = imgrot_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = imgrot_pkg::MAX_HEIGHT_DEF,
    parameter int unsigned ENTRY_W    = 1
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // queue read side
    input  logic                                 empty,
    output logic                                 pop,
    input  logic [ENTRY_W-1:0]                   pop_data,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [imgrot_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                 m_tlast
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    imgrot_pkg::entry_info_t info;
    logic [AW-1:0] addr;

    logic [imgrot_pkg::PIXEL_W-1:0] frame_mem [DEPTH];
    logic [imgrot_pkg::PIXEL_W-1:0] mem_rd_reg;

    logic                            p1_valid_reg, p1_valid_next;
    logic [imgrot_pkg::COORD_W-1:0]  p1_col_reg, p1_row_reg;
    logic                            p1_last_reg;

    logic                            m_valid_reg, m_valid_next;
    logic [imgrot_pkg::PIXEL_W-1:0]  out_pix_reg;
    logic [imgrot_pkg::COORD_W-1:0]  out_col_reg, out_row_reg;
    logic                            out_last_reg;

    logic p1_adv, pop_store, pop_read;

    assign info = imgrot_pkg::entry_info_t'(pop_data[ENTRY_W-1:AW]);
    assign addr = pop_data[AW-1:0];

    // Stores retire at once; reads wait for a free slot in the read stage
    always_comb begin
        p1_adv    = p1_valid_reg && (!m_valid_reg || m_tready);
        pop_store = !empty && (info.kind == imgrot_pkg::CMD_STORE);
        pop_read  = !empty && (info.kind == imgrot_pkg::CMD_READ) &&
                    (!p1_valid_reg || p1_adv);
        pop       = pop_store || pop_read;
        p1_valid_next = pop_read ? 1'b1 : (p1_adv ? 1'b0 : p1_valid_reg);
        m_valid_next  = p1_adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    // Frame store: one write or one registered read per cycle
    always_ff @(posedge aclk) begin
        if (pop_store) begin
            frame_mem[addr] <= info.pixel;
        end
        if (pop_read) begin
            mem_rd_reg <= frame_mem[addr];
            p1_col_reg  <= info.col;
            p1_row_reg  <= info.row;
            p1_last_reg <= info.last;
        end
        if (p1_adv) begin
            out_pix_reg  <= mem_rd_reg;
            out_col_reg  <= p1_col_reg;
            out_row_reg  <= p1_row_reg;
            out_last_reg <= p1_last_reg;
        end
    end

    // Stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_row_reg, out_col_reg, out_pix_reg};

    // A popped read always occupies the read stage next cycle
    a_read_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        pop_read |=> p1_valid_reg)
        else $error("popped read did not reach the read stage");

    // Read data held while the read stage is blocked
    a_rd_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_adv) |=> $stable(mem_rd_reg))
        else $error("read data overwritten while stalled");

endmodule

// File: hdl/image_rotate_quarter_turns_core.sv
// ----------------------------------------------------------------------------
// image_rotate_quarter_turns_core
// Quarter-turn RGB frame rotator: stores a source frame in raster order and
// streams it back turned by 90, 180 or 270 degrees, or unchanged.
//
//   Channel  Dir  Handshake           Payload
//   cfg      in   cfg_valid/ready     cfg_index (register), cfg_data (value)
//   s_       in   s_tvalid/tready     s_tuser command, s_tdata RGB pixel
//   m_       out  m_tvalid/tready     m_tdata pixel + coordinates, m_tlast
//
// One command is taken per cycle while the four-entry command queue has room.
// A store leaves the queue once it reaches the head and is written to the
// frame store; a read passes from the queue through the frame store read
// register into the output register, which holds the result on m_.
// Reset (aresetn low at a clock edge) clears counters, queue and valid flags
// and loads 128 x 128, 90 degrees; the frame store itself is not cleared.
// A stall on m_ backs up reads into the queue and then s_tready drops.
// ----------------------------------------------------------------------------
module image_rotate_quarter_turns_core #(
    parameter int unsigned MAX_WIDTH  = imgrot_pkg::MAX_WIDTH_DEF,
    parameter int unsigned MAX_HEIGHT = imgrot_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imgrot_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imgrot_pkg::DIM_W-1:0]         cfg_data,
    // command stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tuser,  // [0] command
    input  logic [imgrot_pkg::PIXEL_W-1:0]       s_tdata,  // pixel_red, pixel_green, pixel_blue
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [imgrot_pkg::OUT_DATA_W-1:0]    m_tdata,  // out_red, out_green, out_blue,
                                                           // out_col, out_row, 2'b0 pad
    output logic                                 m_tlast
);

    localparam int unsigned AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int unsigned ENTRY_W = $bits(imgrot_pkg::entry_info_t) + AW;

    logic               q_push, q_full, q_pop, q_empty;
    logic [ENTRY_W-1:0] q_push_data, q_pop_data;

    // Accept and classify commands
    imgrot_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full)
    );

    // Decouple front and back
    imgrot_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (imgrot_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    // Frame store and result stream
    imgrot_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (q_empty),
        .pop      (q_pop),
        .pop_data (q_pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
